[sv/mfd_pkg.sv]
// ============================================================================
// mfd_pkg: shared types and constants for the motor feedback frame decoder
// Field widths, register codes, gearbox scale constants and stage structs.
// ============================================================================
package mfd_pkg;

    // Frame and state widths
    localparam int ID_W         = 11;
    localparam int ANGLE_W      = 16;
    localparam int DELTA_W      = ANGLE_W + 2;
    localparam int MAG_W        = 16;
    localparam int POS_W        = 56;
    localparam int SPEED_W      = 32;
    localparam int MOTOR_ID_W   = 4;
    localparam int MOTOR_TYPE_W = 2;

    // Stream beats
    localparam int S_TDATA_W  = 3 * ANGLE_W;
    localparam int M_FIELDS_W = 1 + 2 * ANGLE_W + 2 * POS_W + SPEED_W + ANGLE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_BIT = 2;

    localparam logic REG_MOTOR_ID   = 1'b0;
    localparam logic REG_MOTOR_TYPE = 1'b1;

    localparam logic [MOTOR_TYPE_W-1:0] TYPE_GEAR_19 = 2'd0;   // 3591/187 gearbox
    localparam logic [MOTOR_TYPE_W-1:0] TYPE_GEAR_36 = 2'd1;   // 36:1 gearbox

    localparam logic [MOTOR_ID_W-1:0]   MOTOR_ID_RESET   = 4'd1;
    localparam logic [MOTOR_TYPE_W-1:0] MOTOR_TYPE_RESET = TYPE_GEAR_19;

    // Encoder unwrap
    localparam int COUNTS_PER_TURN = 8192;
    localparam int WRAP_LIMIT      = 4000;
    localparam logic signed [DELTA_W-1:0] WRAP_HI   = DELTA_W'(WRAP_LIMIT);
    localparam logic signed [DELTA_W-1:0] WRAP_LO   = DELTA_W'(-WRAP_LIMIT);
    localparam logic signed [DELTA_W-1:0] TURN_SPAN = DELTA_W'(COUNTS_PER_TURN);

    // Position increment magnitude = |d| * K + round((|d| * R) / D)
    // 3591/187 gearbox: |d|*15319040/399 -> K = 38393, R = 233, D = 399
    // 36:1 gearbox:     |d|*20480 exactly
    localparam int POS_MAG_W  = 32;
    localparam int POS_INC_W  = POS_MAG_W + 1;
    localparam int POS_SUM_W  = POS_W + 1;
    localparam logic [MAG_W-1:0] POS_HI_K19 = 16'd38393;
    localparam logic [MAG_W-1:0] POS_HI_K36 = 16'd20480;
    // (|d|*233 + 199) / 399 via reciprocal 21528659 / 2^33
    localparam int POS_FRAC_PROD_W = 49;
    localparam int POS_FRAC_SHIFT  = 33;
    localparam int POS_FRAC_W      = 16;
    localparam logic [32:0] POS_FRAC_GAIN = 33'd5016177547;
    localparam logic [31:0] POS_FRAC_BIAS = 32'd4284203141;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Speed magnitude = |s| * K + remainder term
    // 3591/187: |s|*12255232/3591 -> K = 3412, rem (|s|*2740 + 1795) / 3591
    // 36:1:     |s|*16384/9       -> K = 1820, rem (|s|*4 + 4) / 9
    localparam int SPD_MAG_W = 28;
    localparam int SPD_K_W   = 12;
    localparam logic [SPD_K_W-1:0] SPD_HI_K19 = 12'd3412;
    localparam logic [SPD_K_W-1:0] SPD_HI_K36 = 12'd1820;
    // reciprocal 153092681 / 2^39
    localparam int SPD19_PROD_W  = 55;
    localparam int SPD19_SHIFT   = 39;
    localparam int SPD19_FRAC_W  = 15;
    localparam logic [38:0] SPD19_GAIN = 39'd419473945940;
    localparam logic [38:0] SPD19_BIAS = 39'd274801362395;
    // reciprocal 466034 / 2^22
    localparam int SPD36_PROD_W  = 37;
    localparam int SPD36_SHIFT   = 22;
    localparam int SPD36_FRAC_W  = 14;
    localparam logic [20:0] SPD36_GAIN = 21'd1864136;
    localparam logic [20:0] SPD36_BIAS = 21'd1864136;

    typedef struct packed {
        logic [MOTOR_ID_W-1:0]   motor_id;
        logic [MOTOR_TYPE_W-1:0] motor_type;
    } mfd_cfg_t;

    typedef struct packed {
        logic                      matched;
        logic                      enabled;
        logic signed [ANGLE_W-1:0] enc_now;
        logic signed [ANGLE_W-1:0] enc_before;
        logic [MOTOR_TYPE_W-1:0]   motor_type;
        logic                      delta_neg;
        logic [MAG_W-1:0]          delta_mag;
        logic                      speed_neg;
        logic [MAG_W-1:0]          speed_mag;
        logic signed [ANGLE_W-1:0] current;
    } mfd_unwrap_t;

    typedef struct packed {
        logic                      matched;
        logic                      enabled;
        logic signed [ANGLE_W-1:0] enc_now;
        logic signed [ANGLE_W-1:0] enc_before;
        logic                      scale_en;
        logic                      pos_neg;
        logic [POS_MAG_W-1:0]      pos_mag;
        logic                      speed_neg;
        logic [SPD_MAG_W-1:0]      speed_mag;
        logic signed [ANGLE_W-1:0] current;
    } mfd_scale_t;

    typedef struct packed {
        logic                      matched;
        logic                      enabled;
        logic signed [ANGLE_W-1:0] enc_now;
        logic signed [ANGLE_W-1:0] enc_before;
        logic signed [POS_W-1:0]   pos_deg;
        logic signed [POS_W-1:0]   pos_before;
        logic signed [SPEED_W-1:0] speed;
        logic signed [ANGLE_W-1:0] current;
    } mfd_result_t;

endpackage

[sv/mfd_cfg_regs.sv]
// ============================================================================
// mfd_cfg_regs: configuration registers
// APB-style write/read of motor_id (byte 0) and motor_type (byte 4).
// ============================================================================
module mfd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output mfd_pkg::mfd_cfg_t                 cfg
);
    import mfd_pkg::*;

    mfd_cfg_t cfg_reg;
    logic     reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_BIT];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motor_id   <= MOTOR_ID_RESET;
            cfg_reg.motor_type <= MOTOR_TYPE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MOTOR_ID:   cfg_reg.motor_id   <= pwdata[MOTOR_ID_W-1:0];
                REG_MOTOR_TYPE: cfg_reg.motor_type <= pwdata[MOTOR_TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MOTOR_ID:   prdata = APB_DATA_W'(cfg_reg.motor_id);
            REG_MOTOR_TYPE: prdata = APB_DATA_W'(cfg_reg.motor_type);
            default:        prdata = '0;
        endcase
    end

endmodule

[sv/mfd_unwrap.sv]
// ============================================================================
// mfd_unwrap: id match, encoder pair update and delta unwrap
// Holds the encoder pair and enable flag; registers one unwrapped beat.
// ============================================================================
module mfd_unwrap (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mfd_pkg::mfd_cfg_t                    cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mfd_pkg::ID_W-1:0]             std_id,
    input  logic signed [mfd_pkg::ANGLE_W-1:0]   angle_word,
    input  logic signed [mfd_pkg::ANGLE_W-1:0]   speed_word,
    input  logic signed [mfd_pkg::ANGLE_W-1:0]   current_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mfd_pkg::mfd_unwrap_t                 out_data
);
    import mfd_pkg::*;

    logic                      enable_reg;
    logic signed [ANGLE_W-1:0] enc_latest_reg;
    logic signed [ANGLE_W-1:0] enc_prev_reg;
    logic                      valid_reg;
    mfd_unwrap_t               data_reg;
    mfd_unwrap_t               data_next;

    logic                      accept;
    logic                      hit;
    logic signed [ANGLE_W-1:0] prev_next;
    logic signed [DELTA_W-1:0] delta_raw;
    logic signed [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0]        delta_abs;
    logic signed [ANGLE_W:0]   speed_ext;
    logic [ANGLE_W:0]          speed_abs;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign hit = (std_id[MOTOR_ID_W-1:0] == cfg.motor_id);

    always_comb begin
        // both stored angles zero: seed the pair with the new angle
        if (enc_latest_reg == '0 && enc_prev_reg == '0) begin
            prev_next = angle_word;
        end else begin
            prev_next = enc_latest_reg;
        end

        delta_raw = DELTA_W'(angle_word) - DELTA_W'(prev_next);
        if (delta_raw > WRAP_HI) begin
            delta = delta_raw - TURN_SPAN;
        end else if (delta_raw < WRAP_LO) begin
            delta = delta_raw + TURN_SPAN;
        end else begin
            delta = delta_raw;
        end
        delta_abs = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);

        speed_ext = (ANGLE_W+1)'(speed_word);
        speed_abs = speed_ext[ANGLE_W] ? (ANGLE_W+1)'(-speed_ext) : (ANGLE_W+1)'(speed_ext);

        data_next.matched    = hit;
        data_next.enabled    = enable_reg | hit;
        data_next.enc_now    = hit ? angle_word : enc_latest_reg;
        data_next.enc_before = hit ? prev_next : enc_prev_reg;
        data_next.motor_type = cfg.motor_type;
        data_next.delta_neg  = delta[DELTA_W-1];
        data_next.delta_mag  = delta_abs[MAG_W-1:0];
        data_next.speed_neg  = speed_ext[ANGLE_W];
        data_next.speed_mag  = speed_abs[MAG_W-1:0];
        data_next.current    = current_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            enable_reg     <= 1'b0;
            enc_latest_reg <= '0;
            enc_prev_reg   <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept && hit) begin
                enable_reg     <= 1'b1;
                enc_prev_reg   <= prev_next;
                enc_latest_reg <= angle_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/mfd_scale.sv]
// ============================================================================
// mfd_scale: gearbox scaling of encoder delta and rotor speed
// Constant multiplies with reciprocal rounding; one registered stage.
// ============================================================================
module mfd_scale (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mfd_pkg::mfd_unwrap_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mfd_pkg::mfd_scale_t   out_data
);
    import mfd_pkg::*;

    logic                       valid_reg;
    mfd_scale_t                 data_reg;
    mfd_scale_t                 data_next;

    logic                       gear19;
    logic                       gear36;
    logic [MAG_W-1:0]           pos_k;
    logic [POS_MAG_W-1:0]       pos_hi;
    logic [POS_FRAC_PROD_W-1:0] pos_frac_prod;
    logic [POS_FRAC_W-1:0]      pos_frac;
    logic [SPD_K_W-1:0]         spd_k;
    logic [SPD_MAG_W-1:0]       spd_hi;
    logic [SPD19_PROD_W-1:0]    spd19_prod;
    logic [SPD36_PROD_W-1:0]    spd36_prod;
    logic [SPD19_FRAC_W-1:0]    spd_frac;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        gear19 = (in_data.motor_type == TYPE_GEAR_19);
        gear36 = (in_data.motor_type == TYPE_GEAR_36);

        pos_k  = gear19 ? POS_HI_K19 : POS_HI_K36;
        pos_hi = POS_MAG_W'(in_data.delta_mag) * POS_MAG_W'(pos_k);
        pos_frac_prod = POS_FRAC_PROD_W'(in_data.delta_mag) * POS_FRAC_PROD_W'(POS_FRAC_GAIN)
                      + POS_FRAC_PROD_W'(POS_FRAC_BIAS);
        pos_frac = gear19 ? pos_frac_prod[POS_FRAC_SHIFT +: POS_FRAC_W] : '0;

        spd_k  = gear19 ? SPD_HI_K19 : SPD_HI_K36;
        spd_hi = SPD_MAG_W'(in_data.speed_mag) * SPD_MAG_W'(spd_k);
        spd19_prod = SPD19_PROD_W'(in_data.speed_mag) * SPD19_PROD_W'(SPD19_GAIN)
                   + SPD19_PROD_W'(SPD19_BIAS);
        spd36_prod = SPD36_PROD_W'(in_data.speed_mag) * SPD36_PROD_W'(SPD36_GAIN)
                   + SPD36_PROD_W'(SPD36_BIAS);
        spd_frac = gear19 ? spd19_prod[SPD19_SHIFT +: SPD19_FRAC_W]
                          : SPD19_FRAC_W'(spd36_prod[SPD36_SHIFT +: SPD36_FRAC_W]);

        data_next.matched    = in_data.matched;
        data_next.enabled    = in_data.enabled;
        data_next.enc_now    = in_data.enc_now;
        data_next.enc_before = in_data.enc_before;
        data_next.scale_en   = gear19 | gear36;
        data_next.pos_neg    = in_data.delta_neg;
        data_next.pos_mag    = pos_hi + POS_MAG_W'(pos_frac);
        data_next.speed_neg  = in_data.speed_neg;
        data_next.speed_mag  = spd_hi + SPD_MAG_W'(spd_frac);
        data_next.current    = in_data.current;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/mfd_accum.sv]
// ============================================================================
// mfd_accum: position accumulator and result register
// Saturating 56-bit position, speed and current state; drives the result beat.
// ============================================================================
module mfd_accum (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mfd_pkg::mfd_scale_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mfd_pkg::mfd_result_t  result
);
    import mfd_pkg::*;

    logic                        valid_reg;
    logic                        matched_reg;
    logic                        enabled_reg;
    logic signed [ANGLE_W-1:0]   enc_now_reg;
    logic signed [ANGLE_W-1:0]   enc_before_reg;
    logic signed [POS_W-1:0]     pos_accum_reg;
    logic signed [POS_W-1:0]     pos_prior_reg;
    logic signed [SPEED_W-1:0]   speed_reg;
    logic signed [ANGLE_W-1:0]   current_reg;

    logic                        load;
    logic signed [POS_INC_W-1:0] inc;
    logic signed [POS_SUM_W-1:0] sum;
    logic signed [POS_W-1:0]     pos_accum_next;
    logic signed [SPEED_W-1:0]   speed_next;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;

    always_comb begin
        inc = in_data.pos_neg ? -(POS_INC_W'(in_data.pos_mag)) : POS_INC_W'(in_data.pos_mag);
        sum = POS_SUM_W'(pos_accum_reg) + POS_SUM_W'(inc);
        // clamp on overflow of the 56-bit range
        if (sum[POS_SUM_W-1] != sum[POS_SUM_W-2]) begin
            pos_accum_next = sum[POS_SUM_W-1] ? POS_MIN : POS_MAX;
        end else begin
            pos_accum_next = sum[POS_W-1:0];
        end
        speed_next = in_data.speed_neg ? -(SPEED_W'(in_data.speed_mag))
                                       : SPEED_W'(in_data.speed_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            pos_accum_reg <= '0;
            pos_prior_reg <= '0;
            speed_reg     <= '0;
            current_reg   <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load && in_data.matched) begin
                pos_prior_reg <= pos_accum_reg;
                current_reg   <= in_data.current;
                if (in_data.scale_en) begin
                    pos_accum_reg <= pos_accum_next;
                    speed_reg     <= speed_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            matched_reg    <= in_data.matched;
            enabled_reg    <= in_data.enabled;
            enc_now_reg    <= in_data.enc_now;
            enc_before_reg <= in_data.enc_before;
        end
    end

    assign result.matched    = matched_reg;
    assign result.enabled    = enabled_reg;
    assign result.enc_now    = enc_now_reg;
    assign result.enc_before = enc_before_reg;
    assign result.pos_deg    = pos_accum_reg;
    assign result.pos_before = pos_prior_reg;
    assign result.speed      = speed_reg;
    assign result.current    = current_reg;

endmodule

[sv/motor_feedback_frame_decoder.sv]
// ============================================================================
// motor_feedback_frame_decoder: motor feedback frame decoder, top level
// Decodes feedback frames into unwrapped shaft position, speed and current.
// ============================================================================
// Takes one feedback frame per beat on the s_ stream and returns one result
// beat per frame on the m_ stream, in order. A frame whose low four id bits
// equal motor_id updates the encoder pair, unwraps the 8192-count delta and,
// for the two gearbox types, scales it by the gearbox ratio into degrees
// (signed, 24 fraction bits, saturating at 56 bits) and scales rotor rpm into
// shaft rpm (16 fraction bits); other frames leave the state alone and report
// it with matched = 0. Throughput is one frame per clock while m_tready stays
// high. The frame passes three registers: an unwrap register, a multiply
// register and the result register, where the position accumulator closes
// its loop within a single stage. Configuration is written over the APB port;
// the user must write it only while the stream is idle, the block does not
// enforce this.
// ============================================================================
module motor_feedback_frame_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // frame input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] angle_word, [31:16] speed_word, [47:32] current_word
    input  logic [mfd_pkg::S_TDATA_W-1:0]       s_tdata,
    // [10:0] std_id
    input  logic [mfd_pkg::ID_W-1:0]            s_tuser,
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] enabled, [16:1] encoder_now, [32:17] encoder_before,
    // [88:33] position_deg, [144:89] position_before, [176:145] speed_out,
    // [192:177] current_out, [199:193] zero
    output logic [mfd_pkg::M_TDATA_W-1:0]       m_tdata,
    // [0] matched
    output logic                                m_tuser,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mfd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mfd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import mfd_pkg::*;

    mfd_cfg_t    cfg;
    mfd_unwrap_t unwrap_data;
    mfd_scale_t  scale_data;
    mfd_result_t result;
    logic        unwrap_valid;
    logic        unwrap_ready;
    logic        scale_valid;
    logic        scale_ready;

    logic signed [ANGLE_W-1:0] angle_word;
    logic signed [ANGLE_W-1:0] speed_word;
    logic signed [ANGLE_W-1:0] current_word;

    // split the input beat into its words
    assign angle_word   = s_tdata[ANGLE_W-1:0];
    assign speed_word   = s_tdata[2*ANGLE_W-1:ANGLE_W];
    assign current_word = s_tdata[3*ANGLE_W-1:2*ANGLE_W];

    mfd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 1: match, update encoder pair, unwrap delta
    mfd_unwrap u_unwrap (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .std_id       (s_tuser),
        .angle_word   (angle_word),
        .speed_word   (speed_word),
        .current_word (current_word),
        .out_valid    (unwrap_valid),
        .out_ready    (unwrap_ready),
        .out_data     (unwrap_data)
    );

    // stage 2: gearbox scaling
    mfd_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (unwrap_valid),
        .in_ready  (unwrap_ready),
        .in_data   (unwrap_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    // stage 3: accumulate position, hold the result beat
    mfd_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // pack the result beat, lowest field first
    assign m_tuser = result.matched;
    assign m_tdata = {{M_PAD_W{1'b0}},
                      result.current,
                      result.speed,
                      result.pos_before,
                      result.pos_deg,
                      result.enc_before,
                      result.enc_now,
                      result.enabled};

endmodule

[sv/mfd_checker.sv]
// ============================================================================
// mfd_checker: port-level checks for the motor feedback frame decoder
// Watches the stream ports over time; bound to the top level.
// ============================================================================
module mfd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mfd_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tuser
);
    import mfd_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset drains the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a matched frame always leaves the block enabled
    a_match_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[0])
        else $error("matched result without enable");

    // a free result register lets the whole pipeline advance
    a_input_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output can advance");

endmodule

bind motor_feedback_frame_decoder mfd_checker u_mfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/tb_motor_feedback_frame_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_motor_feedback_frame_decoder: self-checking bench for the frame decoder
// Drives feedback frames and APB register writes, predicts every result beat
// with a cycle-free model of the decoder and compares each field in order.
// ============================================================================
module tb_motor_feedback_frame_decoder;

    import mfd_pkg::*;

    // Motor types without a package name: no scaling, and the spare code
    localparam logic [MOTOR_TYPE_W-1:0] TYPE_DIRECT = 2'd2;
    localparam logic [MOTOR_TYPE_W-1:0] TYPE_SPARE  = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_MOTOR_ID   = {REG_MOTOR_ID, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MOTOR_TYPE = {REG_MOTOR_TYPE, 2'b00};

    localparam longint POS_HI = 64'sd36028797018963967;
    localparam longint POS_LO = -POS_HI - 1;

    // Cycles to let pass after the last result before touching a register
    localparam int DRAIN_SLACK    = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int FRAMES_PER_PHASE = 150;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [ID_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    motor_feedback_frame_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Decoder shadow state: configuration plus everything the block keeps
    // ------------------------------------------------------------------------
    logic [MOTOR_ID_W-1:0]    cfg_motor_id;
    logic [MOTOR_TYPE_W-1:0]  cfg_motor_type;
    bit                       enable_seen;
    logic signed [ANGLE_W-1:0] enc_latest;
    logic signed [ANGLE_W-1:0] enc_previous;
    longint                   pos_accum;
    longint                   pos_prior;
    longint                   shaft_speed;
    logic signed [ANGLE_W-1:0] current_val;

    mfd_result_t              pending_results[$];
    int                       mismatch_count;
    bit                       pace_on;
    logic signed [ANGLE_W-1:0] last_angle;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the whole run; the slowest legal run is far below this
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Divide with rounding to nearest, ties away from zero
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Apply one frame to the shadow state and return the beat it must produce
    function automatic mfd_result_t decode_frame(logic [ID_W-1:0] std_id,
                                                 logic signed [ANGLE_W-1:0] angle,
                                                 logic signed [ANGLE_W-1:0] speed,
                                                 logic signed [ANGLE_W-1:0] current);
        mfd_result_t r;
        longint      delta;
        longint      inc;
        longint      sum;
        bit          hit;
        hit = (std_id[MOTOR_ID_W-1:0] == cfg_motor_id);
        if (hit) begin
            enable_seen = 1'b1;
            // Both encoder slots empty: seed both, so the first delta is zero
            if (enc_latest == 0 && enc_previous == 0) begin
                enc_previous = angle;
                enc_latest   = angle;
            end else begin
                enc_previous = enc_latest;
                enc_latest   = angle;
            end
            pos_prior = pos_accum;

            // Unwrap: pull a jump of more than WRAP_LIMIT counts one turn back
            delta = longint'(enc_latest) - longint'(enc_previous);
            if (delta > WRAP_LIMIT)
                delta -= COUNTS_PER_TURN;
            else if (delta < -WRAP_LIMIT)
                delta += COUNTS_PER_TURN;

            if (cfg_motor_type == TYPE_GEAR_19 || cfg_motor_type == TYPE_GEAR_36) begin
                if (cfg_motor_type == TYPE_GEAR_19) begin
                    inc = round_div(delta * 360 * 187 * (64'sd1 <<< 24),
                                    longint'(3591) * COUNTS_PER_TURN);
                    shaft_speed = round_div(longint'(speed) * 187 * 65536, 3591);
                end else begin
                    inc = round_div(delta * 360 * (64'sd1 <<< 24),
                                    longint'(36) * COUNTS_PER_TURN);
                    shaft_speed = round_div(longint'(speed) * 65536, 36);
                end
                sum = pos_accum + inc;
                if (sum > POS_HI)
                    sum = POS_HI;
                else if (sum < POS_LO)
                    sum = POS_LO;
                pos_accum = sum;
            end
            current_val = current;
        end
        r.matched    = hit;
        r.enabled    = enable_seen;
        r.enc_now    = enc_latest;
        r.enc_before = enc_previous;
        r.pos_deg    = pos_accum[POS_W-1:0];
        r.pos_before = pos_prior[POS_W-1:0];
        r.speed      = shaft_speed[SPEED_W-1:0];
        r.current    = current_val;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s expected 0x%0h got 0x%0h", $realtime, name, exp_v, act_v);
        end
    endtask

    // Signed fields go in as raw bits so they compare against the packed slices
    task automatic check_result_beat();
        mfd_result_t exp_r;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: result beat with no frame outstanding", $realtime);
            return;
        end
        exp_r = pending_results.pop_front();
        compare_field("matched",         exp_r.matched,    m_tuser);
        compare_field("enabled",         exp_r.enabled,    m_tdata[0]);
        compare_field("encoder_now",     $unsigned(exp_r.enc_now),    m_tdata[16:1]);
        compare_field("encoder_before",  $unsigned(exp_r.enc_before), m_tdata[32:17]);
        compare_field("position_deg",    $unsigned(exp_r.pos_deg),    m_tdata[88:33]);
        compare_field("position_before", $unsigned(exp_r.pos_before), m_tdata[144:89]);
        compare_field("speed_out",       $unsigned(exp_r.speed),      m_tdata[176:145]);
        compare_field("current_out",     $unsigned(exp_r.current),    m_tdata[192:177]);
        compare_field("tdata padding",   '0,               m_tdata[M_TDATA_W-1:193]);
    endtask

    // Sample at the edge; values seen here are the ones from before the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result_beat();
    end

    // ------------------------------------------------------------------------
    // Pacing
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one; none while pacing is off
    function automatic int pick_gap();
        int r;
        if (!pace_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result-side backpressure: drop m_tready for a random stretch
    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one frame beat; s_tvalid stays high into the next call unless a gap
    task automatic send_frame(logic [ID_W-1:0] std_id, logic signed [ANGLE_W-1:0] angle,
                              logic signed [ANGLE_W-1:0] speed,
                              logic signed [ANGLE_W-1:0] current);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= std_id;
        s_tdata  <= {current, speed, angle};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(decode_frame(std_id, angle, speed, current));
        last_angle = angle;
    endtask

    // Hold the input until every outstanding result is back, plus pipeline slack
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // Setup and access phases, then idle before the next transfer
    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MOTOR_ID)
            cfg_motor_id = data[MOTOR_ID_W-1:0];
        else if (addr == ADDR_MOTOR_TYPE)
            cfg_motor_type = data[MOTOR_TYPE_W-1:0];
        @(posedge aclk);
    endtask

    task automatic read_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] exp_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        compare_field("prdata", exp_v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain, then write both registers with junk above the field and read back
    task automatic set_config(logic [MOTOR_ID_W-1:0] id, logic [MOTOR_TYPE_W-1:0] mtype);
        logic [APB_DATA_W-1:0] junk;
        drain_results();
        junk = $urandom();
        write_reg(ADDR_MOTOR_ID, {junk[APB_DATA_W-1:MOTOR_ID_W], id});
        junk = $urandom();
        write_reg(ADDR_MOTOR_TYPE, {junk[APB_DATA_W-1:MOTOR_TYPE_W], mtype});
        read_reg(ADDR_MOTOR_ID, APB_DATA_W'(id));
        read_reg(ADDR_MOTOR_TYPE, APB_DATA_W'(mtype));
    endtask

    function automatic logic [ID_W-1:0] own_id();
        logic [ID_W-1:0] id;
        id = $urandom();
        id[MOTOR_ID_W-1:0] = cfg_motor_id;
        return id;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of both registers, the seeding of empty encoders and the
    // unwrap thresholds on both sides, with field extremes
    task automatic test_reset_and_unwrap();
        read_reg(ADDR_MOTOR_ID, APB_DATA_W'(MOTOR_ID_RESET));
        read_reg(ADDR_MOTOR_TYPE, APB_DATA_W'(MOTOR_TYPE_RESET));
        send_frame(11'h7FE, 16'sh7FFF, 16'sh1234, 16'sh4321);   // other id: state untouched
        send_frame(11'h001, 16'sd0, 16'sd32767, -16'sd32768);   // match, encoders stay empty
        send_frame(11'h7F1, 16'sd100, -16'sd32768, 16'sd32767); // seed both encoders
        send_frame(11'h001, 16'sd4100, 16'sd1, 16'sd0);         // +4000: just inside
        send_frame(11'h001, 16'sd8101, -16'sd1, 16'sd5);        // +4001: wraps back
        send_frame(11'h001, 16'sd4101, 16'sd5, -16'sd5);        // -4000: just inside
        send_frame(11'h001, 16'sd100, -16'sd5, 16'sd0);         // -4001: wraps forward
        send_frame(11'h001, 16'sd32767, 16'sd0, 16'sd0);
        send_frame(11'h001, -16'sd32768, 16'sd0, 16'sd0);       // largest negative jump
        send_frame(11'h001, 16'sd32767, 16'sd0, 16'sd0);        // largest positive jump
        send_frame(11'h001, 16'sd0, 16'sd0, 16'sd0);
        send_frame(11'h001, 16'sd0, 16'sd0, 16'sd0);            // both encoders zero again
        send_frame(11'h001, 16'sd500, 16'sd0, 16'sd0);          // reseed
    endtask

    // Every motor type: both gearboxes scale, the other two hold position and speed
    task automatic test_motor_types();
        logic [MOTOR_TYPE_W-1:0] mtype;
        for (int t = 0; t < 4; t++) begin
            mtype = MOTOR_TYPE_W'(t);
            set_config(MOTOR_ID_RESET, mtype);
            send_frame(11'h001, 16'sd3500, 16'sd32767, 16'sd77);
            send_frame(11'h001, 16'sd7999, -16'sd32768, -16'sd77);
            send_frame(11'h001, 16'sd50, -16'sd7, 16'sd1);
        end
    endtask

    // Identifier match at both ends of the motor_id range
    task automatic test_id_select();
        set_config(4'd0, TYPE_GEAR_36);
        send_frame(11'h000, 16'sd1200, 16'sd300, 16'sd10);
        send_frame(11'h7FF, 16'sd2200, 16'sd300, 16'sd10);  // no match
        set_config(4'd15, TYPE_GEAR_36);
        send_frame(11'h7FF, 16'sd3200, -16'sd300, 16'sd10);
        send_frame(11'h7F0, 16'sd4200, -16'sd300, 16'sd10); // no match
    endtask

    // Pick the next angle: mostly an encoder walk within one turn, some jumps
    // near the unwrap threshold, some zeros and some raw noise
    function automatic logic signed [ANGLE_W-1:0] next_angle();
        int r;
        int a;
        r = $urandom_range(0, 99);
        a = int'(last_angle);
        if (r < 60)
            return ANGLE_W'((a + int'($urandom_range(0, 1200)) - 600) & (COUNTS_PER_TURN - 1));
        else if (r < 75)
            return ANGLE_W'(a + ($urandom_range(0, 1) ? 1 : -1)
                            * int'($urandom_range(WRAP_LIMIT - 10, WRAP_LIMIT + 10)));
        else if (r < 83)
            return '0;
        return ANGLE_W'($urandom());
    endfunction

    // Random phases, each under a fresh configuration; some with no pacing,
    // some with a full stop of the input halfway through
    task automatic test_random_traffic();
        logic [MOTOR_ID_W-1:0]   id;
        logic [MOTOR_TYPE_W-1:0] mtype;
        logic [ID_W-1:0]         std_id;
        int                      pick;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pace_on = (p % 3 != 2);
            id = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : MOTOR_ID_W'($urandom());
            pick = $urandom_range(0, 9);
            mtype = (pick < 4) ? TYPE_GEAR_19 : (pick < 8) ? TYPE_GEAR_36 :
                    (pick < 9) ? TYPE_DIRECT : TYPE_SPARE;
            if (p < 4)
                mtype = MOTOR_TYPE_W'(p);
            set_config(id, mtype);
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                if (n == FRAMES_PER_PHASE / 2 && p % 3 == 1)
                    drain_results();
                std_id = ($urandom_range(0, 99) < 85) ? own_id() : ID_W'($urandom());
                send_frame(std_id, next_angle(), ANGLE_W'($urandom()), ANGLE_W'($urandom()));
            end
        end
        pace_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;

        cfg_motor_id   = MOTOR_ID_RESET;
        cfg_motor_type = MOTOR_TYPE_RESET;
        enable_seen    = 1'b0;
        enc_latest     = '0;
        enc_previous   = '0;
        pos_accum      = 0;
        pos_prior      = 0;
        shaft_speed    = 0;
        current_val    = '0;
        mismatch_count = 0;
        last_angle     = '0;
        pace_on        = 1'b1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_and_unwrap();
        test_motor_types();
        test_id_select();
        test_random_traffic();

        // Wait out every result and the pipeline behind it
        drain_results();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
